@@ sv/assert_macros.svh @@
// Assertion macros for the matrix multiplier; empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset
`define AST_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked on every rising edge outside reset
`define AST_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AST_IMPLY(lbl, ante, cons)
`define AST_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/mm_pkg.sv @@
// Shared constants and control types for the matrix multiplier.
`timescale 1ns / 1ps

package mm_pkg;

    // Parameter defaults
    localparam int MAX_DIM_DEF      = 8;
    localparam int ELEMENT_BITS_DEF = 16;

    // Fixed field widths
    localparam int ENTRY_W   = 40;
    localparam int OUT_IDX_W = 3;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    // Register indices
    localparam logic [CFG_IDX_W-1:0] REG_A_ROWS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_B_COLS     = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // take the input word into a store
        logic start;       // final load word: clear indices and accumulator
        logic issue;       // read one A/B pair and advance k
        logic next_entry;  // move the accumulator to the output, advance i/j
    } mm_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic load_last;   // the next load word completes B
        logic k_last;      // k is at the final inner step
        logic pipe_busy;   // reads or products still in flight
        logic out_free;    // output register can take a word this cycle
        logic entry_last;  // current entry is the final one of the matrix
    } mm_status_t;

endpackage

@@ sv/mm_ctrl.sv @@
// Controller state machine: load, multiply-accumulate and drain phases.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mm_ctrl
    import mm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  mm_status_t status,
    output mm_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_MAC   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Take input words only while loading
    assign in_ready = (state_reg == ST_LOAD);

    // Drive datapath commands
    always_comb
    begin
        cmd.load       = in_valid && (state_reg == ST_LOAD);
        cmd.start      = cmd.load && status.load_last;
        cmd.issue      = (state_reg == ST_MAC);
        cmd.next_entry = (state_reg == ST_DRAIN) && !status.pipe_busy && status.out_free;
    end

    // Advance the phase
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (cmd.start)
                begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC:
            begin
                if (status.k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (cmd.next_entry)
                begin
                    state_next = status.entry_last ? ST_LOAD : ST_MAC;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Return to loading once the final entry has gone to the output
    `AST_NEXT(a_last_entry_to_load, cmd.next_entry && status.entry_last, state_reg == ST_LOAD)
    // Drain only follows the final inner step
    `AST_IMPLY(a_drain_after_k_last, $rose(state_reg == ST_DRAIN), $past(status.k_last))

endmodule

@@ sv/mm_datapath.sv @@
// Datapath: configuration, element stores, address counters and the MAC pipeline.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mm_datapath
    import mm_pkg::*;
#(
    parameter int MAX_DIM      = MAX_DIM_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_W-1:0]               cfg_data,
    input  logic signed [ELEMENT_BITS-1:0] element,
    input  logic                           out_ready,
    input  mm_cmd_t                        cmd,
    output mm_status_t                     status,
    output logic                           out_valid,
    output logic signed [ENTRY_W-1:0]      product_entry,
    output logic [OUT_IDX_W-1:0]           row_index,
    output logic [OUT_IDX_W-1:0]           col_index,
    output logic                           last
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W  = $clog2(2 * DEPTH + 1);
    localparam int PROD_W = 2 * ELEMENT_BITS;
    localparam int EXT_W  = (PROD_W > ENTRY_W) ? PROD_W : ENTRY_W;

    // Clamp a register value to 1..MAX_DIM
    function automatic logic [DIM_W-1:0] dim_of(input logic [CFG_W-1:0] v);
        logic [DIM_W-1:0] d;
        if (v == '0)
        begin
            d = DIM_W'(1);
        end
        else if (32'(v) > MAX_DIM)
        begin
            d = DIM_W'(MAX_DIM);
        end
        else
        begin
            d = DIM_W'(v);
        end
        return d;
    endfunction

    logic [CFG_W-1:0]               a_rows_reg;
    logic [CFG_W-1:0]               inner_size_reg;
    logic [CFG_W-1:0]               b_cols_reg;
    logic [DIM_W-1:0]               rows;
    logic [DIM_W-1:0]               inner;
    logic [DIM_W-1:0]               cols;
    logic [DIM_W-1:0]               inner_m1;
    logic [CNT_W-1:0]               a_total;
    logic [CNT_W-1:0]               total;
    logic                           cfg_hit;

    logic [CNT_W-1:0]               load_count_reg;
    logic [CNT_W-1:0]               load_count_next;
    logic                           in_a;
    logic [ADDR_W-1:0]              a_wr_addr;
    logic [ADDR_W-1:0]              b_wr_addr;

    logic [ELEMENT_BITS-1:0]        a_mem [DEPTH];
    logic [ELEMENT_BITS-1:0]        b_mem [DEPTH];

    logic [IDX_W-1:0]               i_reg;
    logic [IDX_W-1:0]               j_reg;
    logic [IDX_W-1:0]               k_reg;
    logic [ADDR_W-1:0]              a_base_reg;
    logic [ADDR_W-1:0]              a_addr_reg;
    logic [ADDR_W-1:0]              b_addr_reg;
    logic                           row_end;
    logic [ADDR_W-1:0]              a_base_step;

    logic                           rd_v_reg;
    logic                           prod_v_reg;
    logic signed [ELEMENT_BITS-1:0] a_rd_reg;
    logic signed [ELEMENT_BITS-1:0] b_rd_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [EXT_W-1:0]        prod_ext;
    logic [ENTRY_W-1:0]             acc_reg;

    logic                           out_valid_reg;
    logic [ENTRY_W-1:0]             out_entry_reg;
    logic [OUT_IDX_W-1:0]           out_row_reg;
    logic [OUT_IDX_W-1:0]           out_col_reg;
    logic                           out_last_reg;

    // Effective dimensions and load totals
    always_comb
    begin
        rows     = dim_of(a_rows_reg);
        inner    = dim_of(inner_size_reg);
        cols     = dim_of(b_cols_reg);
        inner_m1 = inner - 1'b1;
        a_total  = CNT_W'(rows) * CNT_W'(inner);
        total    = a_total + CNT_W'(inner) * CNT_W'(cols);
    end

    // Decode configuration writes
    always_comb
    begin
        unique case (cfg_index)
            REG_A_ROWS:     cfg_hit = cfg_write;
            REG_INNER_SIZE: cfg_hit = cfg_write;
            REG_B_COLS:     cfg_hit = cfg_write;
            default:        cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_rows_reg     <= CFG_RESET;
            inner_size_reg <= CFG_RESET;
            b_cols_reg     <= CFG_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_A_ROWS)
            begin
                a_rows_reg <= cfg_data;
            end
            if (cfg_index == REG_INNER_SIZE)
            begin
                inner_size_reg <= cfg_data;
            end
            if (cfg_index == REG_B_COLS)
            begin
                b_cols_reg <= cfg_data;
            end
        end
    end

    // Count load words; a register write drops a partial load
    always_comb
    begin
        in_a      = (load_count_reg < a_total);
        a_wr_addr = ADDR_W'(load_count_reg);
        b_wr_addr = ADDR_W'(load_count_reg - a_total);

        load_count_next = load_count_reg;
        priority if (cfg_hit)
        begin
            load_count_next = '0;
        end
        else if (cmd.start)
        begin
            load_count_next = '0;
        end
        else if (cmd.load)
        begin
            load_count_next = CNT_W'(load_count_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
        end
        else
        begin
            load_count_reg <= load_count_next;
        end
    end

    // Element stores: one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.load && in_a)
        begin
            a_mem[a_wr_addr] <= element;
        end
        if (cmd.load && !in_a)
        begin
            b_mem[b_wr_addr] <= element;
        end
        if (cmd.issue)
        begin
            a_rd_reg <= a_mem[a_addr_reg];
            b_rd_reg <= b_mem[b_addr_reg];
        end
    end

    // Walk i, j, k with running store addresses
    always_comb
    begin
        row_end     = (DIM_W'(j_reg) == cols - 1'b1);
        a_base_step = ADDR_W'(a_base_reg + inner);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            a_base_reg <= '0;
            a_addr_reg <= '0;
            b_addr_reg <= '0;
        end
        else if (cmd.issue)
        begin
            if (!status.k_last)
            begin
                k_reg <= k_reg + 1'b1;
            end
            a_addr_reg <= a_addr_reg + 1'b1;
            b_addr_reg <= ADDR_W'(b_addr_reg + cols);
        end
        else if (cmd.next_entry)
        begin
            k_reg <= '0;
            if (row_end)
            begin
                i_reg      <= i_reg + 1'b1;
                j_reg      <= '0;
                a_base_reg <= a_base_step;
                a_addr_reg <= a_base_step;
                b_addr_reg <= '0;
            end
            else
            begin
                j_reg      <= j_reg + 1'b1;
                a_addr_reg <= a_base_reg;
                b_addr_reg <= ADDR_W'(j_reg + 1'b1);
            end
        end
    end

    // Track reads and products in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_v_reg   <= 1'b0;
            prod_v_reg <= 1'b0;
        end
        else
        begin
            rd_v_reg   <= cmd.issue;
            prod_v_reg <= rd_v_reg;
        end
    end

    // Multiply, then accumulate modulo 2^40
    assign prod_ext = EXT_W'(prod_reg);

    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
        begin
            prod_reg <= a_rd_reg * b_rd_reg;
        end
        if (cmd.start || cmd.next_entry)
        begin
            acc_reg <= '0;
        end
        else if (prod_v_reg)
        begin
            acc_reg <= acc_reg + prod_ext[ENTRY_W-1:0];
        end
    end

    // Output register: hold the word until the receiver takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.next_entry)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.next_entry)
        begin
            out_entry_reg <= acc_reg;
            out_row_reg   <= OUT_IDX_W'(i_reg);
            out_col_reg   <= OUT_IDX_W'(j_reg);
            out_last_reg  <= status.entry_last;
        end
    end

    // Report status to the controller
    always_comb
    begin
        status.load_last  = (CNT_W'(load_count_reg + 1'b1) == total);
        status.k_last     = (DIM_W'(k_reg) == inner_m1);
        status.pipe_busy  = rd_v_reg || prod_v_reg;
        status.out_free   = !out_valid_reg || out_ready;
        status.entry_last = row_end && (DIM_W'(i_reg) == rows - 1'b1);
    end

    assign out_valid     = out_valid_reg;
    assign product_entry = out_entry_reg;
    assign row_index     = out_row_reg;
    assign col_index     = out_col_reg;
    assign last          = out_last_reg;

    // A load word always lands inside the current load
    `AST_IMPLY(a_load_in_range, cmd.load, load_count_reg < total)
    // An entry leaves only with the pipeline empty and room at the output
    `AST_IMPLY(a_emit_when_settled, cmd.next_entry,
               !rd_v_reg && !prod_v_reg && (!out_valid_reg || out_ready))

endmodule

@@ sv/matrix_multiply.sv @@
// Top level of the matrix multiplier: controller and datapath.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready/element): one signed Q8.8 word per
//   transfer, all of A row-major, then all of B row-major.
//   Output channel (out_valid/out_ready): one Q24.16 entry per word with its
//   row_index and col_index, in row-major order; last marks the final entry.
//   Configuration: cfg_write with cfg_index selects a_rows (0), inner_size (1)
//   or b_cols (2); 0 acts as 1, values above MAX_DIM act as MAX_DIM. A write
//   drops any partial load. Write only while idle.
//   Loading accepts an input word in every cycle in which in_valid is high. After
//   the last B word, each entry is computed on the single multiply-accumulate
//   pipeline (store read, multiply, add) and then moved to the output register.
//   in_ready is low from the last B word until the final entry has entered
//   the output register. A stalled receiver holds the output word and
//   pauses the next entry at its drain step.
//   Reset clears the load count and sets all dimensions to 8; the element
//   stores are not cleared and need no clearing pass.

module matrix_multiply
    import mm_pkg::*;
#(
    parameter int MAX_DIM      = MAX_DIM_DEF,
    parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_W-1:0]               cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic signed [ELEMENT_BITS-1:0] element,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [ENTRY_W-1:0]      product_entry,
    output logic [OUT_IDX_W-1:0]           row_index,
    output logic [OUT_IDX_W-1:0]           col_index,
    output logic                           last
);

    mm_cmd_t    cmd;
    mm_status_t status;

    // Phase control
    mm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // Stores, counters and MAC pipeline
    mm_datapath #(
        .MAX_DIM      (MAX_DIM),
        .ELEMENT_BITS (ELEMENT_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .element       (element),
        .out_ready     (out_ready),
        .cmd           (cmd),
        .status        (status),
        .out_valid     (out_valid),
        .product_entry (product_entry),
        .row_index     (row_index),
        .col_index     (col_index),
        .last          (last)
    );

endmodule
